@@ rtl/button_debounce_click_hold_unit_macros.svh @@
// assertion helpers used by the bound checker
`ifndef BUTTON_DEBOUNCE_CLICK_HOLD_UNIT_MACROS_SVH
`define BUTTON_DEBOUNCE_CLICK_HOLD_UNIT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define BDCH_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on every rising clock edge out of reset
`define BDCH_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/bdch_pkg.sv @@
package bdch_pkg;

   // configuration register layout
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLICK_MAX = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD      = 2'd2;

   localparam logic [CSR_DATA_W-1:0] DEBOUNCE_RESET  = 16'd30;
   localparam logic [CSR_DATA_W-1:0] CLICK_MAX_RESET = 16'd1500;
   localparam logic [CSR_DATA_W-1:0] HOLD_RESET      = 16'd2000;

   // button and channel numbering
   localparam logic [3:0] COMBINED_BUTTON = 4'd5;
   localparam logic [3:0] EXPANDER_COUNT  = 4'd8;
   localparam logic [3:0] DIRECT_BUTTON   = 4'd8;
   localparam logic [3:0] CH_DIRECT       = 4'd7;
   localparam logic [3:0] CH_AROMA        = 4'd8;
   localparam logic [3:0] CH_ION          = 4'd9;
   localparam logic CMD_CLICK = 1'b0;
   localparam logic CMD_HOLD  = 1'b1;

   typedef struct packed {
      logic [31:0] now_ms;
      logic [7:0]  expander_port;
      logic        port_fresh;
      logic        direct_level;
   } req_type;

   typedef struct packed {
      logic [3:0] channel;
      logic       command;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] channel;
      logic       command;
   } event_map_type;

   // button number and event kind to output channel and command
   function automatic event_map_type map_event(input logic [3:0] button, input logic hold);
      event_map_type m;
      m.valid   = 1'b1;
      m.channel = button;
      m.command = hold;
      if (button == COMBINED_BUTTON) begin
         m.channel = hold ? CH_ION : CH_AROMA;
         m.command = CMD_CLICK;
      end else if (button < COMBINED_BUTTON) begin
         m.channel = button;
      end else if (button < EXPANDER_COUNT) begin
         m.channel = button - 4'd1;
      end else if (button == DIRECT_BUTTON) begin
         m.channel = CH_DIRECT;
      end else begin
         m.valid = 1'b0;
      end
      return m;
   endfunction

endpackage

@@ rtl/button_debounce_click_hold_unit.sv @@
// channel | ports                                  | transaction
// req     | req_valid, req_stall, req_data         | one tick: time stamp, expander, pin
// rsp     | rsp_valid, rsp_stall, rsp_data         | one click or hold event
// csr     | csr_write_enable, csr_index, csr_write_data | one register write
//
// a tick is accepted in the idle state, then the buttons are scanned in order,
// each with a debounce step and, when a debounce test passes or a press is
// timed, a press step, then a flush step follows; all steps use the single
// shared subtract-and-compare unit. the first tick after reset only captures levels.
// an event stalls the scan only while both the output register and the
// pending event slot are full. reset is synchronous, active high.
module button_debounce_click_hold_unit #(
   parameter int unsigned BUTTON_COUNT = 9
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  bdch_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bdch_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write_enable,
   input  logic [bdch_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bdch_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam int unsigned IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUTTON_COUNT - 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_DEB   = 2'd1;
   localparam logic [1:0] ST_PRS   = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   // control
   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             started_ff, started_in;
   logic             pend_valid_ff, pend_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // configuration
   logic [15:0] debounce_ff, debounce_in;
   logic [15:0] click_max_ff, click_max_in;
   logic [15:0] hold_ff, hold_in;

   // payload
   logic [31:0]       now_ff, now_in;
   bdch_pkg::rsp_type pend_ff, pend_in;
   bdch_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // per-button state
   logic        raw_ff        [BUTTON_COUNT];
   logic        raw_in        [BUTTON_COUNT];
   logic [31:0] raw_time_ff   [BUTTON_COUNT];
   logic [31:0] raw_time_in   [BUTTON_COUNT];
   logic        stable_ff     [BUTTON_COUNT];
   logic        stable_in     [BUTTON_COUNT];
   logic [31:0] press_time_ff [BUTTON_COUNT];
   logic [31:0] press_time_in [BUTTON_COUNT];
   logic        hold_sent_ff  [BUTTON_COUNT];
   logic        hold_sent_in  [BUTTON_COUNT];

   // scan datapath
   logic [31:0]             op_time;
   logic [31:0]             diff;
   logic [16:0]             limit;
   logic                    ge;
   logic                    out_free;
   logic                    cur_raw;
   logic                    cur_stable;
   logic                    cur_hold_sent;
   logic                    fire;
   logic                    ev;
   logic                    done;
   logic                    push;
   bdch_pkg::rsp_type       push_data;
   bdch_pkg::event_map_type ev_map;
   logic [15:0]             src_pressed;
   logic [15:0]             src_live;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // button sources: expander bits 0-7, direct pin at button 8, none beyond
   assign src_pressed = {7'd0, ~req_data.direct_level, ~req_data.expander_port};
   assign src_live    = {7'd0, 1'b1, {8{req_data.port_fresh}}};

   // shared subtract-and-compare unit
   assign cur_raw       = raw_ff[idx_ff];
   assign cur_stable    = stable_ff[idx_ff];
   assign cur_hold_sent = hold_sent_ff[idx_ff];
   assign op_time  = (state_ff == ST_DEB) ? raw_time_ff[idx_ff] : press_time_ff[idx_ff];
   assign diff     = now_ff - op_time;
   always_comb begin
      if (state_ff == ST_DEB) begin
         limit = {1'b0, debounce_ff};
      end else if (cur_stable) begin
         limit = {1'b0, hold_ff};
      end else begin
         limit = {1'b0, click_max_ff} + 17'd1;
      end
   end
   assign ge       = (diff >= {15'd0, limit});
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign ev_map   = bdch_pkg::map_event(4'(idx_ff), cur_stable);

   // configuration writes
   always_comb begin
      debounce_in  = debounce_ff;
      click_max_in = click_max_ff;
      hold_in      = hold_ff;
      if (csr_write_enable) begin
         case (csr_index)
            bdch_pkg::CSR_DEBOUNCE:  debounce_in  = csr_write_data;
            bdch_pkg::CSR_CLICK_MAX: click_max_in = csr_write_data;
            bdch_pkg::CSR_HOLD:      hold_in      = csr_write_data;
            default: ;
         endcase
      end
   end

   // scan sequencer
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      started_in    = started_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      now_in        = now_ff;
      raw_in        = raw_ff;
      raw_time_in   = raw_time_ff;
      stable_in     = stable_ff;
      press_time_in = press_time_ff;
      hold_sent_in  = hold_sent_ff;
      fire          = 1'b0;
      ev            = 1'b0;
      done          = 1'b0;
      push          = 1'b0;
      push_data     = pend_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               now_in = req_data.now_ms;
               if (!started_ff) begin
                  // first tick only captures the current levels
                  for (int k = 0; k < BUTTON_COUNT; k++) begin
                     raw_in[k]        = src_pressed[k];
                     raw_time_in[k]   = req_data.now_ms;
                     press_time_in[k] = req_data.now_ms;
                     stable_in[k]     = src_pressed[k];
                     hold_sent_in[k]  = src_pressed[k];
                  end
                  started_in = 1'b1;
                  state_in   = ST_FLUSH;
               end else begin
                  // raw level change tracking
                  for (int k = 0; k < BUTTON_COUNT; k++) begin
                     if (src_live[k] && (raw_ff[k] != src_pressed[k])) begin
                        raw_in[k]      = src_pressed[k];
                        raw_time_in[k] = req_data.now_ms;
                     end
                  end
                  idx_in   = '0;
                  state_in = ST_DEB;
               end
            end
         end
         ST_DEB: begin
            if (cur_raw != cur_stable) begin
               if (ge) begin
                  // debounced level change
                  stable_in[idx_ff] = cur_raw;
                  if (cur_raw) begin
                     press_time_in[idx_ff] = now_ff;
                     hold_sent_in[idx_ff]  = 1'b0;
                  end
                  state_in = ST_PRS;
               end else begin
                  done = 1'b1;
               end
            end else if (cur_stable && !cur_hold_sent) begin
               state_in = ST_PRS;
            end else begin
               done = 1'b1;
            end
         end
         ST_PRS: begin
            // pressed: hold test, released: click test
            fire = cur_stable ? ge : (!cur_hold_sent && !ge);
            ev   = fire && ev_map.valid;
            if (!(ev && pend_valid_ff && !out_free)) begin
               if (cur_stable) begin
                  if (ge) begin
                     hold_sent_in[idx_ff] = 1'b1;
                  end
               end else begin
                  hold_sent_in[idx_ff] = 1'b0;
               end
               if (ev) begin
                  push           = pend_valid_ff;
                  push_data      = pend_ff;
                  push_data.last = 1'b0;
                  pend_in.channel = ev_map.channel;
                  pend_in.command = ev_map.command;
                  pend_in.last    = 1'b0;
                  pend_valid_in   = 1'b1;
               end
               done = 1'b1;
            end
         end
         ST_FLUSH: begin
            // the held-back event is the last one of the tick
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               push           = 1'b1;
               push_data      = pend_ff;
               push_data.last = 1'b1;
               pend_valid_in  = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // step to the next button
      if (done) begin
         if (idx_ff == IDX_LAST) begin
            state_in = ST_FLUSH;
         end else begin
            idx_in   = idx_ff + 1'b1;
            state_in = ST_DEB;
         end
      end
   end

   // output register
   assign rsp_valid_in = push ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign rsp_data_in  = push ? push_data : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         started_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         debounce_ff   <= bdch_pkg::DEBOUNCE_RESET;
         click_max_ff  <= bdch_pkg::CLICK_MAX_RESET;
         hold_ff       <= bdch_pkg::HOLD_RESET;
      end else begin
         state_ff      <= state_in;
         started_ff    <= started_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         debounce_ff   <= debounce_in;
         click_max_ff  <= click_max_in;
         hold_ff       <= hold_in;
      end
   end

   // payload and per-button state
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      now_ff        <= now_in;
      pend_ff       <= pend_in;
      rsp_data_ff   <= rsp_data_in;
      raw_ff        <= raw_in;
      raw_time_ff   <= raw_time_in;
      stable_ff     <= stable_in;
      press_time_ff <= press_time_in;
      hold_sent_ff  <= hold_sent_in;
   end

endmodule

@@ rtl/bdch_checker.sv @@
`include "button_debounce_click_hold_unit_macros.svh"

module bdch_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input bdch_pkg::req_type                req_data,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input bdch_pkg::rsp_type                rsp_data,
   input logic                             csr_write_enable,
   input logic [bdch_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [bdch_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   // a stalled event stays on the port unchanged
   `BDCH_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "rsp changed while stalled")

   // the block is busy in the cycle after taking a tick
   `BDCH_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall, "tick accepted back to back")

   // channels stop at the ion channel
   `BDCH_ASSERT_NOW(a_channel_range, rsp_valid, rsp_data.channel <= bdch_pkg::CH_ION, "channel out of range")

   // the combined button only ever reports clicks
   `BDCH_ASSERT_NOW(a_combined_click, rsp_valid && (rsp_data.command == bdch_pkg::CMD_HOLD), rsp_data.channel < bdch_pkg::CH_AROMA, "hold on combined channel")

endmodule

bind button_debounce_click_hold_unit bdch_checker u_bdch_checker (.*);

@@ bench/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bdch_pkg::*;

   localparam int CLOCK_PERIOD    = 12;
   localparam int NUM_BUTTONS     = 9;
   localparam int SETTLE_CYCLES   = 60;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PROGRESS_LIMIT  = 3000;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   // expected click and hold events, computed from each accepted tick
   class click_hold_scoreboard;
      logic [CSR_DATA_W-1:0] debounce_ms;
      logic [CSR_DATA_W-1:0] click_max_ms;
      logic [CSR_DATA_W-1:0] hold_ms;
      logic        raw_pressed    [NUM_BUTTONS];
      logic [31:0] raw_since      [NUM_BUTTONS];
      logic        stable_pressed [NUM_BUTTONS];
      logic [31:0] press_start    [NUM_BUTTONS];
      logic        hold_done      [NUM_BUTTONS];
      logic        started;
      rsp_type     expected_events [$];
      int          failures;

      function new();
         debounce_ms  = DEBOUNCE_RESET;
         click_max_ms = CLICK_MAX_RESET;
         hold_ms      = HOLD_RESET;
         foreach (raw_pressed[k]) begin
            raw_pressed[k]    = 1'b0;
            raw_since[k]      = '0;
            stable_pressed[k] = 1'b0;
            press_start[k]    = '0;
            hold_done[k]      = 1'b0;
         end
         started  = 1'b0;
         failures = 0;
      endfunction

      task report(string what);
         failures++;
         $display("mismatch at %0t: %s", $realtime, what);
      endtask

      function void set_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_DEBOUNCE:  debounce_ms  = value;
            CSR_CLICK_MAX: click_max_ms = value;
            CSR_HOLD:      hold_ms      = value;
            default: ;
         endcase
      endfunction

      function logic [31:0] elapsed_ms(logic [31:0] now, logic [31:0] mark);
         return now - mark;
      endfunction

      // button number to channel, combined button folds hold into the ion click
      function rsp_type make_event(int button, logic command);
         rsp_type e;
         e.command = command;
         e.last    = 1'b0;
         if (button == COMBINED_BUTTON) begin
            e.channel = (command == CMD_HOLD) ? CH_ION : CH_AROMA;
            e.command = CMD_CLICK;
         end else if (button == DIRECT_BUTTON) begin
            e.channel = CH_DIRECT;
         end else if (button > COMBINED_BUTTON) begin
            e.channel = 4'(button - 1);
         end else begin
            e.channel = 4'(button);
         end
         return e;
      endfunction

      function void note_tick(req_type t);
         logic    pressed [NUM_BUTTONS];
         rsp_type found [$];
         for (int k = 0; k < NUM_BUTTONS; k++)
            pressed[k] = (k < EXPANDER_COUNT) ? !t.expander_port[k] : !t.direct_level;

         // first tick only latches levels, buttons already down stay silent
         if (!started) begin
            for (int k = 0; k < NUM_BUTTONS; k++) begin
               raw_pressed[k]    = pressed[k];
               raw_since[k]      = t.now_ms;
               press_start[k]    = t.now_ms;
               stable_pressed[k] = pressed[k];
               hold_done[k]      = pressed[k];
            end
            started = 1'b1;
            return;
         end

         // raw levels, expander only when freshly read
         for (int k = 0; k < NUM_BUTTONS; k++) begin
            if ((k == DIRECT_BUTTON || t.port_fresh) && raw_pressed[k] != pressed[k]) begin
               raw_pressed[k] = pressed[k];
               raw_since[k]   = t.now_ms;
            end
         end

         // debounce, click on release, one hold per press
         for (int k = 0; k < NUM_BUTTONS; k++) begin
            if (raw_pressed[k] != stable_pressed[k]) begin
               if (elapsed_ms(t.now_ms, raw_since[k]) < {16'd0, debounce_ms})
                  continue;
               stable_pressed[k] = raw_pressed[k];
               if (stable_pressed[k]) begin
                  press_start[k] = t.now_ms;
                  hold_done[k]   = 1'b0;
               end else begin
                  if (!hold_done[k] &&
                      elapsed_ms(t.now_ms, press_start[k]) <= {16'd0, click_max_ms})
                     found.push_back(make_event(k, CMD_CLICK));
                  hold_done[k] = 1'b0;
               end
            end
            if (!stable_pressed[k] || hold_done[k])
               continue;
            if (elapsed_ms(t.now_ms, press_start[k]) >= {16'd0, hold_ms}) begin
               hold_done[k] = 1'b1;
               found.push_back(make_event(k, CMD_HOLD));
            end
         end

         if (found.size() > 0)
            found[found.size() - 1].last = 1'b1;
         foreach (found[i])
            expected_events.push_back(found[i]);
      endfunction

      task check_event(rsp_type got);
         rsp_type want;
         if (expected_events.size() == 0) begin
            report($sformatf("event with nothing expected: channel %0d command %0d last %0d",
                             got.channel, got.command, got.last));
            return;
         end
         want = expected_events.pop_front();
         if (got.channel !== want.channel)
            report($sformatf("channel %0d, expected %0d", got.channel, want.channel));
         if (got.command !== want.command)
            report($sformatf("command %0d on channel %0d, expected %0d",
                             got.command, want.channel, want.command));
         if (got.last !== want.last)
            report($sformatf("last %0d on channel %0d, expected %0d",
                             got.last, want.channel, want.last));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   click_hold_scoreboard board = new();

   logic [31:0]            tick_time       = '0;
   logic [NUM_BUTTONS-1:0] held_buttons    = '0;
   bit                     steady_flow     = 1'b0;
   bit                     hold_off_request = 1'b0;
   bit                     timed_out       = 1'b0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   button_debounce_click_hold_unit #(
      .BUTTON_COUNT(NUM_BUTTONS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   function automatic req_type tick_of(logic [31:0] now, logic [NUM_BUTTONS-1:0] pressed,
                                       logic fresh);
      req_type t;
      t.now_ms        = now;
      t.expander_port = ~pressed[7:0];
      t.port_fresh    = fresh;
      t.direct_level  = ~pressed[DIRECT_BUTTON];
      return t;
   endfunction

   // offer one tick, with a random gap first, until the block takes it
   task automatic send_tick(req_type t);
      while (!steady_flow && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_tick(t);
   endtask

   task automatic press_at(logic [31:0] now, logic [NUM_BUTTONS-1:0] pressed, logic fresh);
      tick_time = now;
      send_tick(tick_of(now, pressed, fresh));
   endtask

   // write enable stays high across the series and drops once at the end
   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      board.set_register(index, value);
   endtask

   task automatic set_timing(logic [CSR_DATA_W-1:0] debounce, logic [CSR_DATA_W-1:0] click_max,
                             logic [CSR_DATA_W-1:0] hold);
      write_reg(CSR_DEBOUNCE, debounce);
      write_reg(CSR_CLICK_MAX, click_max);
      write_reg(CSR_HOLD, hold);
      write_reg(CSR_UNUSED, CSR_DATA_W'($urandom_range(16'hFFFF)));
      csr_write_enable <= 1'b0;
   endtask

   // all events in, then let a tick with no events finish its scan
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (board.expected_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // buttons change state now and then, with some bounce and stale port reads
   task automatic run_phase(int items, int step_max, int toggle_pct);
      req_type t;
      for (int i = 0; i < items; i++) begin
         if ($urandom_range(99) < 2)
            tick_time += $urandom();
         else
            tick_time += $urandom_range(1, step_max);
         for (int k = 0; k < NUM_BUTTONS; k++)
            if ($urandom_range(99) < toggle_pct)
               held_buttons[k] = !held_buttons[k];
         t = tick_of(tick_time, held_buttons, $urandom_range(99) < 85);
         if ($urandom_range(99) < 8) begin
            t.expander_port = 8'($urandom_range(255));
            t.direct_level  = 1'($urandom_range(1));
         end
         send_tick(t);
      end
   endtask

   task automatic run_test();
      // buttons held at start stay silent after release
      press_at(32'd10, 9'h1A5, 1'b0);
      press_at(32'd50, 9'h000, 1'b1);
      press_at(32'd85, 9'h000, 1'b1);
      // short press on one button gives a click
      press_at(32'd100, 9'h001, 1'b1);
      press_at(32'd131, 9'h001, 1'b1);
      press_at(32'd200, 9'h000, 1'b1);
      press_at(32'd240, 9'h000, 1'b1);
      // combined button and direct pin held exactly to the hold time
      press_at(32'd300, 9'h120, 1'b1);
      press_at(32'd335, 9'h120, 1'b1);
      press_at(32'd2335, 9'h120, 1'b1);
      press_at(32'd2400, 9'h000, 1'b1);
      press_at(32'd2440, 9'h000, 1'b1);
      // stale port read leaves expander buttons alone
      press_at(32'd3200, 9'h0FF, 1'b0);
      // all nine buttons hold together, then click together
      press_at(32'd4000, 9'h1FF, 1'b1);
      press_at(32'd4030, 9'h1FF, 1'b1);
      press_at(32'd6030, 9'h1FF, 1'b1);
      press_at(32'd6100, 9'h000, 1'b1);
      press_at(32'd6130, 9'h000, 1'b1);
      press_at(32'd6200, 9'h1FF, 1'b1);
      press_at(32'd6230, 9'h1FF, 1'b1);
      press_at(32'd6300, 9'h000, 1'b1);
      press_at(32'd6330, 9'h000, 1'b1);

      // reset timing
      run_phase(50, 400, 10);
      wait_until_drained();

      // no debounce, short click and hold windows
      set_timing(16'd0, 16'd8, 16'd15);
      run_phase(60, 4, 10);
      wait_until_drained();

      // widest settings, time stamp wraps
      tick_time = 32'hFFF0_0000;
      set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_phase(50, 30000, 10);
      wait_until_drained();

      // zero hold time, zero click window
      set_timing(16'd3, 16'd0, 16'd0);
      run_phase(40, 6, 10);
      wait_until_drained();

      // busy buttons, long receiver hold-off, then a stretch with no gaps
      set_timing(16'd2, 16'd20, 16'd40);
      run_phase(40, 8, 20);
      hold_off_request = 1'b1;
      run_phase(30, 8, 20);
      steady_flow = 1'b1;
      run_phase(30, 8, 10);
      steady_flow = 1'b0;
      wait_until_drained();

      // click window longer than hold time
      set_timing(16'd1, 16'hFFFF, 16'd1000);
      run_phase(50, 300, 10);
      wait_until_drained();
   endtask

   task automatic watch_progress();
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < PROGRESS_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      timed_out = 1'b1;
      $display("timeout: no transaction for %0d cycles", PROGRESS_LIMIT);
   endtask

   // result side: check each transaction, random stalls and one long hold-off
   initial begin : event_receiver
      int stall_left;
      stall_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            board.check_event(rsp_data);
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall_left = HOLD_OFF_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !steady_flow && ($urandom_range(99) < 17);
         end
      end
   end

   initial begin : main_flow
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_data         <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_DEBOUNCE;
      csr_write_data   <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      fork
         run_test();
         watch_progress();
      join_any
      if (board.expected_events.size() != 0)
         board.report($sformatf("%0d expected events never arrived",
                                board.expected_events.size()));
      if (!timed_out && board.failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
